/* design/stx_etx_lrc_deframer_defines.svh */
// Assertion macros shared by the deframer RTL.
`ifndef STX_ETX_LRC_DEFRAMER_DEFINES_SVH
`define STX_ETX_LRC_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define STXLRC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stxlrc assertion failed");
// Next-cycle implication, checked outside reset
`define STXLRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stxlrc assertion failed");
`else
`define STXLRC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define STXLRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/stxlrc_pkg.sv */
// Types and constants for the STX/ETX LRC deframer.
package stxlrc_pkg;

  // Framing characters
  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_SI    = 8'h0F;
  localparam logic [7:0] CH_SO    = 8'h0E;
  localparam logic [7:0] LRC_INIT = 8'h00;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_NOSTART  = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  // Front-end parse phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_BODY = 4'b0010,
    PH_LRC  = 4'b0100,
    PH_DROP = 4'b1000
  } phase_t;

  // One classified result item
  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    status_t    status;
  } res_t;

endpackage

/* design/stx_etx_lrc_deframer.sv */
// Top level of the STX/ETX LRC deframer.
//
// Input channel (in_valid/in_ready): one received byte per item, with
// in_packet_end marking the last byte of a received packet.
// Output channel (out_valid/out_ready): zero or one result per input item,
// either a stripped payload byte (out_kind 0) or a frame status (out_kind 1,
// out_frame_last 1) with out_status 0 ok, 1 LRC mismatch, 2 no start found,
// 3 truncated.
// Throughput: one byte per cycle while the queue has room; the parse state machine
// in the front end updates once per accepted byte.
// A result is written into the queue at the edge that accepts its byte and is
// moved into the output register once that register is empty or being drained;
// it is taken from there when out_ready is high.
// Stall: the output register and a QUEUE_DEPTH-entry queue absorb results
// while out_ready is low; in_ready drops only once the queue is full.
// Reset (rst_n low, synchronous): parser returns to hunting for a start
// character, LRC clears, queue and output register empty.
module stx_etx_lrc_deframer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_packet_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_payload,
  output logic [1:0] out_status,
  output logic       out_frame_last
);

`include "stx_etx_lrc_deframer_defines.svh"

  logic             q_push, q_push_ready, q_pop, q_valid, q_full;
  stxlrc_pkg::res_t q_wdata, q_rdata;

  stxlrc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .in_packet_end (in_packet_end),
    .q_ready       (q_push_ready),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  stxlrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_rdata),
    .full       (q_full)
  );

  stxlrc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_payload    (out_payload),
    .out_status     (out_status),
    .out_frame_last (out_frame_last)
  );

  // Checks
  `STXLRC_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, q_push, !q_full)
  `STXLRC_ASSERT_IMPL(a_payload_status_zero, clk, rst_n, out_valid && (out_kind == stxlrc_pkg::KIND_PAYLOAD), out_status == stxlrc_pkg::ST_OK && !out_frame_last)
  `STXLRC_ASSERT_IMPL(a_status_payload_zero, clk, rst_n, out_valid && (out_kind == stxlrc_pkg::KIND_STATUS), out_payload == 8'h00)
  `STXLRC_ASSERT_NEXT(a_queued_reaches_out, clk, rst_n, q_valid, out_valid)

endmodule

/* design/stxlrc_front.sv */
// Front end: accepts bytes, tracks framing and LRC, and classifies results.
module stxlrc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  input  logic              in_packet_end,
  input  logic              q_ready,
  output logic              q_push,
  output stxlrc_pkg::res_t  q_data
);

  stxlrc_pkg::phase_t phase_r, phase_nxt;
  logic               mode_r, mode_nxt;     // 1: SI/SO framing
  logic [7:0]         lrc_r, lrc_nxt;
  logic               res_valid;
  stxlrc_pkg::res_t   res;
  logic [7:0]         end_ch;
  logic               in_fire;

  // Every item may yield a result, so only take one when the queue has room
  assign in_ready = q_ready;
  assign in_fire  = in_valid && in_ready;
  assign end_ch   = mode_r ? stxlrc_pkg::CH_SO : stxlrc_pkg::CH_ETX;

  // Parse step
  always_comb begin
    phase_nxt   = phase_r;
    mode_nxt    = mode_r;
    lrc_nxt     = lrc_r;
    res_valid   = 1'b0;
    res.kind    = stxlrc_pkg::KIND_STATUS;
    res.payload = 8'h00;
    res.status  = stxlrc_pkg::ST_OK;
    unique case (phase_r)
      stxlrc_pkg::PH_HUNT: begin
        if (in_rx_byte == stxlrc_pkg::CH_STX || in_rx_byte == stxlrc_pkg::CH_SI) begin
          mode_nxt = (in_rx_byte == stxlrc_pkg::CH_SI);
          lrc_nxt  = stxlrc_pkg::LRC_INIT;
          if (in_packet_end) begin
            res_valid  = 1'b1;
            res.status = stxlrc_pkg::ST_TRUNC;
          end else begin
            phase_nxt = stxlrc_pkg::PH_BODY;
          end
        end else if (in_packet_end) begin
          res_valid  = 1'b1;
          res.status = stxlrc_pkg::ST_NOSTART;
        end
      end
      stxlrc_pkg::PH_BODY: begin
        lrc_nxt = lrc_r ^ in_rx_byte;
        if (in_packet_end) begin
          phase_nxt  = stxlrc_pkg::PH_HUNT;
          res_valid  = 1'b1;
          res.status = stxlrc_pkg::ST_TRUNC;
        end else if (in_rx_byte == end_ch) begin
          phase_nxt = stxlrc_pkg::PH_LRC;
        end else begin
          res_valid   = 1'b1;
          res.kind    = stxlrc_pkg::KIND_PAYLOAD;
          res.payload = in_rx_byte;
        end
      end
      stxlrc_pkg::PH_LRC: begin
        phase_nxt  = in_packet_end ? stxlrc_pkg::PH_HUNT : stxlrc_pkg::PH_DROP;
        res_valid  = 1'b1;
        res.status = (in_rx_byte == lrc_r) ? stxlrc_pkg::ST_OK : stxlrc_pkg::ST_MISMATCH;
      end
      stxlrc_pkg::PH_DROP: begin
        if (in_packet_end) begin
          phase_nxt = stxlrc_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_nxt = stxlrc_pkg::PH_HUNT;
      end
    endcase
  end

  assign q_push = in_fire && res_valid;
  assign q_data = res;

  // State update on accepted items only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= stxlrc_pkg::PH_HUNT;
      mode_r  <= 1'b0;
      lrc_r   <= stxlrc_pkg::LRC_INIT;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      lrc_r   <= lrc_nxt;
    end
  end

endmodule

/* design/stxlrc_queue.sv */
// Small result queue between the front end and the output stage.
module stxlrc_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  stxlrc_pkg::res_t push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output stxlrc_pkg::res_t pop_data,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  stxlrc_pkg::res_t   mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign push_ready = !full;
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

/* design/stxlrc_back.sv */
// Back end: moves queued results into the registered output channel.
module stxlrc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  stxlrc_pkg::res_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_kind,
  output logic [7:0]       out_payload,
  output logic [1:0]       out_status,
  output logic             out_frame_last
);

  logic             out_valid_r;
  stxlrc_pkg::res_t out_data_r;
  logic             load;

  // Load when the output register is empty or being drained this cycle
  assign load  = q_valid && (!out_valid_r || out_ready);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= q_data;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_data_r.kind;
  assign out_payload    = out_data_r.payload;
  assign out_status     = out_data_r.status;
  // Every status result closes its frame
  assign out_frame_last = (out_data_r.kind == stxlrc_pkg::KIND_STATUS);

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the STX/ETX LRC deframer: directed frames, random packets.
module tb_top;

  localparam int HOLD_CYCLES   = 80;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 600;

  // One result as seen on the output channel
  typedef struct packed {
    logic                kind;
    logic [7:0]          payload;
    stxlrc_pkg::status_t status;
    logic                frame_last;
  } frame_res_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_packet_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_kind;
  logic [7:0] out_payload;
  logic [1:0] out_status;
  logic       out_frame_last;

  // Parser copy kept in step with accepted items
  stxlrc_pkg::phase_t parse_phase = stxlrc_pkg::PH_HUNT;
  logic               si_framing = 1'b0;
  logic [7:0]         running_lrc = stxlrc_pkg::LRC_INIT;

  frame_res_t pending_results[$];
  frame_res_t got_res;
  frame_res_t want_res;
  bit         res_due;

  bit no_idle = 1'b0;
  int hold_req = 0;
  int hold_done = 0;
  int err_count = 0;
  int n_items = 0;
  int n_payload = 0;
  int n_status[4] = '{0, 0, 0, 0};
  int n_in_stalls = 0;
  int idle_cycles = 0;

  stx_etx_lrc_deframer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .in_packet_end  (in_packet_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_payload    (out_payload),
    .out_status     (out_status),
    .out_frame_last (out_frame_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Advance the parser by one byte; res_ok tells whether a result comes out
  task automatic parse_byte(input logic [7:0] b, input logic last,
                            output bit res_ok, output frame_res_t r);
    logic [7:0] end_ch;
    res_ok = 1'b0;
    r = '{kind: stxlrc_pkg::KIND_STATUS, payload: 8'h00, status: stxlrc_pkg::ST_OK,
          frame_last: 1'b1};
    end_ch = si_framing ? stxlrc_pkg::CH_SO : stxlrc_pkg::CH_ETX;
    case (parse_phase)
      stxlrc_pkg::PH_HUNT: begin
        if (b == stxlrc_pkg::CH_STX || b == stxlrc_pkg::CH_SI) begin
          si_framing = (b == stxlrc_pkg::CH_SI);
          running_lrc = stxlrc_pkg::LRC_INIT;
          if (last) begin
            res_ok = 1'b1;
            r.status = stxlrc_pkg::ST_TRUNC;
          end else begin
            parse_phase = stxlrc_pkg::PH_BODY;
          end
        end else if (last) begin
          res_ok = 1'b1;
          r.status = stxlrc_pkg::ST_NOSTART;
        end
      end
      stxlrc_pkg::PH_BODY: begin
        running_lrc = running_lrc ^ b;
        if (last) begin
          parse_phase = stxlrc_pkg::PH_HUNT;
          res_ok = 1'b1;
          r.status = stxlrc_pkg::ST_TRUNC;
        end else if (b == end_ch) begin
          parse_phase = stxlrc_pkg::PH_LRC;
        end else begin
          res_ok = 1'b1;
          r = '{kind: stxlrc_pkg::KIND_PAYLOAD, payload: b, status: stxlrc_pkg::ST_OK,
                frame_last: 1'b0};
        end
      end
      stxlrc_pkg::PH_LRC: begin
        parse_phase = last ? stxlrc_pkg::PH_HUNT : stxlrc_pkg::PH_DROP;
        res_ok = 1'b1;
        r.status = (b == running_lrc) ? stxlrc_pkg::ST_OK : stxlrc_pkg::ST_MISMATCH;
      end
      default: begin
        if (last) parse_phase = stxlrc_pkg::PH_HUNT;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic compare_result(input frame_res_t got, input frame_res_t want);
    if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
    if (got.payload != want.payload) report_mismatch("payload", got.payload, want.payload);
    if (got.status != want.status) report_mismatch("status", got.status, want.status);
    if (got.frame_last != want.frame_last)
      report_mismatch("frame_last", got.frame_last, want.frame_last);
  endtask

  // Output check first, then prediction for the item taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got_res = '{kind: out_kind, payload: out_payload,
                    status: stxlrc_pkg::status_t'(out_status), frame_last: out_frame_last};
        if (pending_results.size() == 0) begin
          $display("[%0t] result with nothing pending: kind %0d payload 0x%0h status %0d",
                   $realtime, out_kind, out_payload, out_status);
          err_count++;
        end else begin
          want_res = pending_results.pop_front();
          compare_result(got_res, want_res);
          if (want_res.kind == stxlrc_pkg::KIND_PAYLOAD) n_payload++;
          else n_status[want_res.status]++;
        end
      end
      if (in_valid && in_ready) begin
        n_items++;
        parse_byte(in_rx_byte, in_packet_end, res_due, want_res);
        if (res_due) pending_results.push_back(want_res);
      end
      if (in_valid && !in_ready) n_in_stalls++;
    end
  end

  // Watchdog: too long with no item moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: random backpressure, plus long holds on request
  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_done <= hold_done + 1;
        out_ready <= 1'b1;
      end else if (!no_idle && $urandom_range(99) < 9) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one byte, with random gaps ahead of it, and wait until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!no_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_packet_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Noise, start, body, end, LRC, trailing bytes; cut > 0 truncates the packet
  task automatic send_packet(input bit si, input int n_noise, input int n_body,
                             input bit bad_lrc, input int n_trail, input int cut);
    logic [7:0] pkt[$];
    logic [7:0] ctrl_chars[4];
    logic [7:0] start_ch;
    logic [7:0] end_ch;
    logic [7:0] lrc;
    logic [7:0] b;
    ctrl_chars = '{stxlrc_pkg::CH_STX, stxlrc_pkg::CH_ETX, stxlrc_pkg::CH_SI,
                   stxlrc_pkg::CH_SO};
    start_ch = si ? stxlrc_pkg::CH_SI : stxlrc_pkg::CH_STX;
    end_ch = si ? stxlrc_pkg::CH_SO : stxlrc_pkg::CH_ETX;
    lrc = stxlrc_pkg::LRC_INIT;
    repeat (n_noise) begin
      do b = 8'($urandom_range(255));
      while (b == stxlrc_pkg::CH_STX || b == stxlrc_pkg::CH_SI);
      pkt.push_back(b);
    end
    pkt.push_back(start_ch);
    repeat (n_body) begin
      // framing characters other than the end character are plain payload here
      do begin
        if ($urandom_range(4) == 0) b = ctrl_chars[$urandom_range(3)];
        else b = 8'($urandom_range(255));
      end while (b == end_ch);
      lrc ^= b;
      pkt.push_back(b);
    end
    lrc ^= end_ch;
    pkt.push_back(end_ch);
    pkt.push_back(bad_lrc ? (lrc ^ 8'($urandom_range(255, 1))) : lrc);
    repeat (n_trail) pkt.push_back(8'($urandom_range(255)));
    if (cut > 0) begin
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic send_noise(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(255));
      while (b == stxlrc_pkg::CH_STX || b == stxlrc_pkg::CH_SI);
      send_byte(b, i == n - 1);
    end
  endtask

  // Packets that end before any start character
  task automatic test_no_start();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // Start character as the last byte of a packet
  task automatic test_start_as_last();
    send_byte(stxlrc_pkg::CH_STX, 1'b1);
    send_byte(stxlrc_pkg::CH_SI, 1'b1);
  endtask

  // Good STX frames, one with payload extremes and one with an empty body
  task automatic test_stx_frames();
    send_byte(stxlrc_pkg::CH_STX, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(stxlrc_pkg::CH_ETX, 1'b0);
    send_byte(8'h00 ^ 8'hFF ^ stxlrc_pkg::CH_ETX, 1'b1);
    send_byte(stxlrc_pkg::CH_STX, 1'b0);
    send_byte(stxlrc_pkg::CH_ETX, 1'b0);
    send_byte(stxlrc_pkg::CH_ETX, 1'b1);
  endtask

  // SI frame with STX/ETX in the body, wrong LRC, then bytes dropped to the end mark
  task automatic test_si_frame_mismatch();
    send_byte(stxlrc_pkg::CH_SI, 1'b0);
    send_byte(stxlrc_pkg::CH_STX, 1'b0);
    send_byte(stxlrc_pkg::CH_ETX, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(stxlrc_pkg::CH_SO, 1'b0);
    send_byte(stxlrc_pkg::CH_STX ^ stxlrc_pkg::CH_ETX ^ 8'h80 ^ stxlrc_pkg::CH_SO ^ 8'h01,
              1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(stxlrc_pkg::CH_SI, 1'b1);
  endtask

  // Packet ends on a payload byte and on the end character
  task automatic test_truncated_body();
    send_byte(stxlrc_pkg::CH_STX, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(stxlrc_pkg::CH_SI, 1'b0);
    send_byte(stxlrc_pkg::CH_SO, 1'b1);
  endtask

  // Back-to-back stretch with neither side idling
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (8) send_packet($urandom_range(1), 0, $urandom_range(10), $urandom_range(3) == 0,
                           $urandom_range(1), 0);
    no_idle = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering, so input stalls
  task automatic test_output_hold();
    hold_req <= hold_req + 1;
    no_idle = 1'b1;
    repeat (3) send_packet($urandom_range(1), 1, 12, 1'b0, 0, 0);
    no_idle = 1'b0;
  endtask

  // Mostly well-formed packets with random content; some cut, no-start and raw bytes
  task automatic test_random_packets(input int n);
    int stop_at;
    int sel;
    int n_noise;
    int n_body;
    int n_trail;
    stop_at = n_items + n;
    while (n_items < stop_at) begin
      sel = $urandom_range(99);
      n_noise = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      n_body = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(12);
      n_trail = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
      if (sel < 70) begin
        send_packet($urandom_range(1), n_noise, n_body, $urandom_range(3) == 0, n_trail, 0);
      end else if (sel < 80) begin
        send_packet($urandom_range(1), n_noise, n_body, 1'b0, n_trail,
                    $urandom_range(1, n_noise + n_body + n_trail + 2));
      end else if (sel < 88) begin
        send_noise($urandom_range(1, 4));
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        send_byte(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_start();
    test_start_as_last();
    test_stx_frames();
    test_si_frame_mismatch();
    test_truncated_body();
    test_back_to_back();
    test_output_hold();
    test_random_packets(RANDOM_ITEMS);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d bytes in, %0d payload bytes out, %0d input stall cycles",
             n_items, n_payload, n_in_stalls);
    $display("Frame status seen: ok %0d, lrc mismatch %0d, no start %0d, truncated %0d",
             n_status[stxlrc_pkg::ST_OK], n_status[stxlrc_pkg::ST_MISMATCH],
             n_status[stxlrc_pkg::ST_NOSTART], n_status[stxlrc_pkg::ST_TRUNC]);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
